/* rtl/bcs_pkg.sv */
package bcs_pkg;

  localparam int MaxControlPoints = 8;
  localparam int CoordW = 16;
  localparam int PpcW = 4;
  localparam int TW = 16;
  localparam int WeightW = 36;
  localparam int MulBW = 18;
  localparam int ProdW = WeightW + 1 + MulBW;
  localparam int SumW = 56;
  localparam int FracShift = 30;
  localparam int TShift = 16;
  localparam logic [PpcW-1:0] PpcReset = 4'd4;
  localparam logic [PpcW-1:0] PpcMax = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_WSTEP,
    ST_BINOM,
    ST_MULX,
    ST_MULY,
    ST_NEXTJ,
    ST_ROUND,
    ST_OUT
  } state_t;

  // Binomial coefficient C(n, j) for n up to 7.
  function automatic logic [5:0] binom(input logic [2:0] n, input logic [2:0] j);
    logic [5:0] c;
    c = 6'd0;
    unique case ({n, j})
      6'o00, 6'o10, 6'o11, 6'o20, 6'o22, 6'o30, 6'o33, 6'o40, 6'o44,
      6'o50, 6'o55, 6'o60, 6'o66, 6'o70, 6'o77: c = 6'd1;
      6'o21: c = 6'd2;
      6'o31, 6'o32: c = 6'd3;
      6'o41, 6'o43: c = 6'd4;
      6'o42: c = 6'd6;
      6'o51, 6'o54: c = 6'd5;
      6'o52, 6'o53: c = 6'd10;
      6'o61, 6'o65: c = 6'd6;
      6'o62, 6'o64: c = 6'd15;
      6'o63: c = 6'd20;
      6'o71, 6'o76: c = 6'd7;
      6'o72, 6'o75: c = 6'd21;
      6'o73, 6'o74: c = 6'd35;
      default: c = 6'd0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/bcs_if.sv */
interface bcs_point_if;
  logic valid;
  logic ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface bcs_curve_if;
  logic valid;
  logic ready;
  logic signed [15:0] curve_x;
  logic signed [15:0] curve_y;
  logic last_sample;
  modport source (output valid, curve_x, curve_y, last_sample, input ready);
  modport sink (input valid, curve_x, curve_y, last_sample, output ready);
endinterface

interface bcs_cfg_if;
  logic valid;
  logic ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/bezier_curve_sampler_unit.sv */
// Bezier curve sampler, Bernstein form, signed 12.4 coordinates.
// Control points arrive on the points channel, one per transfer; the transfer
// whose last_point is set closes the curve. Up to MAX_CONTROL_POINTS points are
// kept, later ones are dropped. With count points the block then sends
// count * points_per_control samples on the curves channel, the final one
// with last_sample set. With one or two points, the points are sent back as is.
// points_per_control is written on the cfg channel, which is always ready;
// write it only while the block is idle. Values 0 and above 8 act as 1 and 8.
// A point that does not close a curve is taken while the block stays idle. Per
// sample, the divider forms t = i/N, then the single shared multiplier runs,
// for each point, the weight steps (the last of which only closes the chain),
// then the binomial factor, x, y and a bookkeeping step; then the sums are
// rounded and the sample waits in the output register until it is taken.
// The points channel is not ready while a curve is being evaluated. A stalled
// receiver simply holds the sampler in its output state.
// Reset (synchronous, active high) empties the point store count, returns the
// sequencer to idle and sets points_per_control to 4.
module bezier_curve_sampler_unit
  import bcs_pkg::*;
#(
  parameter int MAX_CONTROL_POINTS = MaxControlPoints
) (
  input  logic        clk,
  input  logic        rst,
  bcs_point_if.sink   points,
  bcs_curve_if.source curves,
  bcs_cfg_if.sink     cfg
);

  localparam int CNT_W = $clog2(MAX_CONTROL_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_CONTROL_POINTS);
  localparam int TOT_W = $clog2(MAX_CONTROL_POINTS * 8 + 1);

  // Point store, written once per kept point, read at index j and, in pass mode, at the sample index.
  logic [CoordW-1:0] store_x [MAX_CONTROL_POINTS];
  logic [CoordW-1:0] store_y [MAX_CONTROL_POINTS];

  state_t state, state_next;

  logic [PpcW-1:0]  ppc;
  logic [CNT_W-1:0] point_count;
  logic [CNT_W-1:0] npts;
  logic             pass_mode;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] sample;
  logic [TW-1:0]    t16;
  logic [TW:0]      omt;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] n;
  logic [WeightW-1:0] w;
  logic signed [SumW-1:0] sx;
  logic signed [SumW-1:0] sy;
  logic [CoordW-1:0] out_x;
  logic [CoordW-1:0] out_y;
  logic              out_last;

  logic             in_xfer;
  logic             out_xfer;
  logic [CNT_W-1:0] count_after;
  logic [PpcW-1:0]  ppc_eff;
  logic [CoordW-1:0] rd_x;
  logic [CoordW-1:0] rd_y;
  logic             div_start;
  logic             div_done;
  logic [TW-1:0]    div_q;
  logic [WeightW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [SumW-1:0] rnd_x;
  logic signed [SumW-1:0] rnd_y;
  logic             is_last_sample;

  assign in_xfer  = points.valid && points.ready;
  assign out_xfer = curves.valid && curves.ready;
  assign n        = IDX_W'(npts - CNT_W'(1));

  // A full store drops the point but still acts on the last_point flag.
  assign count_after = (point_count < CNT_W'(MAX_CONTROL_POINTS)) ?
                       point_count + CNT_W'(1) : point_count;

  always_comb begin
    ppc_eff = ppc;
    if (ppc == '0) ppc_eff = PpcW'(1);
    if (ppc > PpcMax) ppc_eff = PpcMax;
  end

  assign is_last_sample = (sample + TOT_W'(1)) == total;

  bcs_divider #(.TOT_W(TOT_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sample),
    .divisor  (total),
    .done     (div_done),
    .quotient (div_q)
  );

  // The shared multiplier: its first operand is always the running weight.
  always_comb begin
    mul_a = w;
    mul_b = '0;
    case (state)
      ST_WSTEP: mul_b = (k < j) ? MulBW'({1'b0, t16}) : MulBW'(omt);
      ST_BINOM: mul_b = MulBW'(binom(3'(n), 3'(j)));
      ST_MULX:  mul_b = MulBW'($signed(rd_x));
      ST_MULY:  mul_b = MulBW'($signed(rd_y));
      default:  mul_b = '0;
    endcase
  end

  bcs_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  // Round to nearest with ties toward positive infinity.
  assign rnd_x = (sx + (SumW'(1) <<< (FracShift - 1))) >>> FracShift;
  assign rnd_y = (sy + (SumW'(1) <<< (FracShift - 1))) >>> FracShift;

  function automatic logic [CoordW-1:0] sat16(input logic signed [SumW-1:0] v);
    logic [CoordW-1:0] r;
    if (v > SumW'(32767)) r = 16'h7fff;
    else if (v < -SumW'(32768)) r = 16'h8000;
    else r = v[CoordW-1:0];
    return r;
  endfunction

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && points.last_point) begin
          state_next = (count_after <= CNT_W'(2)) ? ST_PASS : ST_DIV_START;
        end
      end
      ST_PASS:      state_next = ST_OUT;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_next = ST_WSTEP;
      ST_WSTEP:     if (k == n) state_next = ST_BINOM;
      ST_BINOM:     state_next = ST_MULX;
      ST_MULX:      state_next = ST_MULY;
      ST_MULY:      state_next = ST_NEXTJ;
      ST_NEXTJ:     state_next = (j == n) ? ST_ROUND : ST_WSTEP;
      ST_ROUND:     state_next = ST_OUT;
      ST_OUT: begin
        if (out_xfer) begin
          if (out_last) state_next = ST_IDLE;
          else state_next = pass_mode ? ST_PASS : ST_DIV_START;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    points.ready = (state == ST_IDLE);
    curves.valid = (state == ST_OUT);
    div_start    = (state == ST_DIV_START);
    cfg.ready    = 1'b1;
  end

  assign curves.curve_x     = out_x;
  assign curves.curve_y     = out_y;
  assign curves.last_sample = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= '0;
      ppc         <= PpcReset;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) ppc <= cfg.data;
      if (in_xfer) point_count <= points.last_point ? '0 : count_after;
    end
  end

  // The point index j holds still for the whole weight chain, so the
  // registered read is settled well before the x and y multiplies.
  always_ff @(posedge clk) begin
    if (in_xfer && (point_count < CNT_W'(MAX_CONTROL_POINTS))) begin
      store_x[point_count[IDX_W-1:0]] <= points.point_x;
      store_y[point_count[IDX_W-1:0]] <= points.point_y;
    end
    rd_x <= store_x[j];
    rd_y <= store_y[j];
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        npts      <= count_after;
        pass_mode <= count_after <= CNT_W'(2);
        total     <= TOT_W'(count_after) * TOT_W'(ppc_eff);
        sample    <= '0;
      end
      ST_PASS: begin
        total    <= TOT_W'(npts);
        out_x    <= store_x[sample[IDX_W-1:0]];
        out_y    <= store_y[sample[IDX_W-1:0]];
        out_last <= (TOT_W'(npts) == sample + TOT_W'(1));
      end
      ST_DIV_WAIT: begin
        t16 <= div_q;
        omt <= (TW + 1)'(1 << TShift) - {1'b0, div_q};
        j   <= '0;
        k   <= '0;
        w   <= WeightW'(1) << FracShift;
        sx  <= '0;
        sy  <= '0;
      end
      ST_WSTEP: begin
        if (k != n) begin
          w <= WeightW'(mul_p >>> TShift);
          k <= k + IDX_W'(1);
        end
      end
      ST_BINOM: w <= WeightW'(mul_p);
      ST_MULX:  sx <= sx + SumW'(mul_p);
      ST_MULY:  sy <= sy + SumW'(mul_p);
      ST_NEXTJ: begin
        j <= j + IDX_W'(1);
        k <= '0;
        w <= WeightW'(1) << FracShift;
      end
      ST_ROUND: begin
        out_x    <= sat16(rnd_x);
        out_y    <= sat16(rnd_y);
        out_last <= is_last_sample;
      end
      ST_OUT: begin
        if (out_xfer) sample <= sample + TOT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

/* rtl/bcs_divider.sv */
module bcs_divider
  import bcs_pkg::*;
#(
  parameter int TOT_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TOT_W-1:0] dividend,
  input  logic [TOT_W-1:0] divisor,
  output logic             done,
  output logic [TW-1:0]    quotient
);

  logic [TOT_W-1:0] rem;
  logic [4:0]       cnt;
  logic             busy;
  logic [TOT_W:0]   rem2;
  logic             ge;

  // Restoring division of dividend * 2^16 by divisor, one quotient bit a cycle.
  // The dividend is below the divisor, so the quotient fits in 16 bits.
  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= 5'(TW);
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? TOT_W'(rem2 - {1'b0, divisor}) : rem2[TOT_W-1:0];
      quotient <= {quotient[TW-2:0], ge};
    end
  end

endmodule

/* rtl/bcs_mul.sv */
module bcs_mul
  import bcs_pkg::*;
(
  input  logic [WeightW-1:0]      a,
  input  logic signed [MulBW-1:0] b,
  output logic signed [ProdW-1:0] p
);

  // Unsigned weight times a signed factor; shared by every multiply step.
  assign p = $signed({1'b0, a}) * b;

endmodule
